### sv/jsu_pkg.sv
package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_UNKNOWN_ESCAPE = 3'd1,
        ERR_BAD_HEX        = 3'd2,
        ERR_TRUNCATED      = 3'd3,
        ERR_MISSING        = 3'd4
    } err_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [2:0] HEX_LAST  = 3'd3;

    typedef struct packed {
        logic        esc;
        logic        in_uni;
        logic [2:0]  hex_cnt;
        logic [15:0] cp;
        logic        err_hold;
    } jsu_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        err_t       err;
    } jsu_res_t;

    typedef struct packed {
        logic [1:0]           cnt;
        jsu_res_t [2:0]       res;
    } jsu_bundle_t;

endpackage

### sv/json_string_unescape_unit.sv
// JSON string body unescaper. Feed the bytes after the opening quote, one beat per
// byte (mode 0), and an end-of-text beat (mode 1) to flush and clear. Each accepted beat
// is decoded in one pass and its results show on the result port from the next cycle,
// one result beat per cycle unless the result side stalls. Plain bytes, single-character
// escapes and quotes give one result each, so they stream at the same rate. A \u escape
// emits its code point as 1 to 3 UTF-8 bytes, and an end of text after an unfinished
// escape gives an error beat and then the end beat; while those results drain, the input
// is stalled until the last one is taken. Bytes that give no result (backslash, \u
// prefix, hex digits, bytes dropped after an error) are taken one per cycle. The first
// error is reported once; later bytes are dropped until end of text.
module json_string_unescape_unit
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       mode,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [2:0] error_code,
    output logic       last
);

    jsu_state_t  state_reg;
    jsu_state_t  state_next;
    jsu_bundle_t bundle_next;
    jsu_bundle_t bundle_reg;
    logic        pend_reg;
    logic [1:0]  idx_reg;
    jsu_res_t    cur;
    logic        last_beat;
    logic        out_take;
    logic        free;
    logic        in_take;

    jsu_decode u_decode (
        .state      (state_reg),
        .mode       (mode),
        .in_byte    (in_byte),
        .state_next (state_next),
        .bundle     (bundle_next)
    );

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = bundle_reg.res[0];
            2'd1:    cur = bundle_reg.res[1];
            default: cur = bundle_reg.res[2];
        endcase
    end

    assign last_beat  = (idx_reg == (bundle_reg.cnt - 2'd1));
    assign out_valid  = pend_reg;
    assign out_take   = pend_reg && !out_stall;
    assign free       = !pend_reg || (out_take && last_beat);
    assign in_stall   = !free;
    assign in_take    = in_valid && free;

    assign kind       = cur.kind;
    assign out_byte   = cur.data;
    assign error_code = cur.err;
    assign last       = last_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            pend_reg  <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (in_take)
        begin
            state_reg <= state_next;
            idx_reg   <= 2'd0;
            pend_reg  <= (bundle_next.cnt != 2'd0);
        end
        else if (out_take)
        begin
            if (last_beat)
            begin
                pend_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // result bundle payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            bundle_reg <= bundle_next;
        end
    end

endmodule

### sv/jsu_decode.sv
module jsu_decode
    import jsu_pkg::*;
(
    input  jsu_state_t  state,
    input  logic        mode,
    input  logic [7:0]  in_byte,
    output jsu_state_t  state_next,
    output jsu_bundle_t bundle
);

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp_shift;
    jsu_res_t    res_none;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            hex_val = in_byte[3:0];
        end
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
        begin
            hex_val = in_byte[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign cp_shift = {state.cp[11:0], hex_val};
    assign res_none = '{kind: KIND_BYTE, data: 8'h00, err: ERR_NONE};

    always_comb
    begin
        state_next = state;
        bundle.cnt = 2'd0;
        bundle.res = {3{res_none}};
        if (mode)
        begin
            state_next = '0;
            if (!state.err_hold && (state.in_uni || state.esc))
            begin
                bundle.cnt    = 2'd2;
                bundle.res[0] = '{kind: KIND_ERROR, data: 8'h00,
                                  err: state.in_uni ? ERR_TRUNCATED : ERR_MISSING};
                bundle.res[1] = '{kind: KIND_END, data: 8'h00, err: ERR_NONE};
            end
            else
            begin
                bundle.cnt    = 2'd1;
                bundle.res[0] = '{kind: KIND_END, data: 8'h00, err: ERR_NONE};
            end
        end
        else if (state.err_hold)
        begin
            bundle.cnt = 2'd0;
        end
        else if (state.in_uni)
        begin
            if (!hex_ok)
            begin
                state_next.in_uni   = 1'b0;
                state_next.hex_cnt  = 3'd0;
                state_next.cp       = 16'h0000;
                state_next.err_hold = 1'b1;
                bundle.cnt          = 2'd1;
                bundle.res[0]       = '{kind: KIND_ERROR, data: 8'h00, err: ERR_BAD_HEX};
            end
            else if (state.hex_cnt == HEX_LAST)
            begin
                state_next.in_uni  = 1'b0;
                state_next.hex_cnt = 3'd0;
                state_next.cp      = 16'h0000;
                if (cp_shift[15:7] == 9'd0)
                begin
                    bundle.cnt    = 2'd1;
                    bundle.res[0] = '{kind: KIND_BYTE, data: cp_shift[7:0], err: ERR_NONE};
                end
                else if (cp_shift[15:11] == 5'd0)
                begin
                    bundle.cnt    = 2'd2;
                    bundle.res[0] = '{kind: KIND_BYTE, data: {3'b110, cp_shift[10:6]},
                                      err: ERR_NONE};
                    bundle.res[1] = '{kind: KIND_BYTE, data: {2'b10, cp_shift[5:0]},
                                      err: ERR_NONE};
                end
                else
                begin
                    bundle.cnt    = 2'd3;
                    bundle.res[0] = '{kind: KIND_BYTE, data: {4'b1110, cp_shift[15:12]},
                                      err: ERR_NONE};
                    bundle.res[1] = '{kind: KIND_BYTE, data: {2'b10, cp_shift[11:6]},
                                      err: ERR_NONE};
                    bundle.res[2] = '{kind: KIND_BYTE, data: {2'b10, cp_shift[5:0]},
                                      err: ERR_NONE};
                end
            end
            else
            begin
                state_next.cp      = cp_shift;
                state_next.hex_cnt = state.hex_cnt + 3'd1;
            end
        end
        else if (state.esc)
        begin
            state_next.esc = 1'b0;
            bundle.cnt     = 2'd1;
            bundle.res[0]  = '{kind: KIND_BYTE, data: 8'h00, err: ERR_NONE};
            unique case (in_byte) inside
                CH_QUOTE, CH_BSLASH, CH_SLASH: bundle.res[0].data = in_byte;
                CH_LC_B: bundle.res[0].data = CH_BS;
                CH_LC_F: bundle.res[0].data = CH_FF;
                CH_LC_N: bundle.res[0].data = CH_LF;
                CH_LC_R: bundle.res[0].data = CH_CR;
                CH_LC_T: bundle.res[0].data = CH_TAB;
                CH_LC_U:
                begin
                    state_next.in_uni  = 1'b1;
                    state_next.hex_cnt = 3'd0;
                    state_next.cp      = 16'h0000;
                    bundle.cnt         = 2'd0;
                end
                default:
                begin
                    state_next.err_hold = 1'b1;
                    bundle.res[0] = '{kind: KIND_ERROR, data: 8'h00,
                                      err: ERR_UNKNOWN_ESCAPE};
                end
            endcase
        end
        else if (in_byte == CH_BSLASH)
        begin
            state_next.esc = 1'b1;
        end
        else if (in_byte == CH_QUOTE)
        begin
            bundle.cnt    = 2'd1;
            bundle.res[0] = '{kind: KIND_CLOSE, data: 8'h00, err: ERR_NONE};
        end
        else
        begin
            bundle.cnt    = 2'd1;
            bundle.res[0] = '{kind: KIND_BYTE, data: in_byte, err: ERR_NONE};
        end
    end

endmodule

### sv/jsu_checker.sv
module jsu_checker
    import jsu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] out_byte,
    input logic [2:0] error_code,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte)
            && $stable(error_code) && $stable(last))
        else $error("result beat changed while stalled");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE)
        else $error("error code on non-error beat");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> out_byte == 8'h00)
        else $error("data on non-byte beat");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_END || kind == KIND_CLOSE) |-> last)
        else $error("end or close beat not marked last");

    a_err_not_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == KIND_ERROR && !last
            |=> out_valid && kind == KIND_END)
        else $error("non-final error not followed by end beat");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .out_byte   (out_byte),
    .error_code (error_code),
    .last       (last)
);

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench
    import jsu_pkg::*;
();

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        err_t       code;
        logic       fin;
    } beat_t;

    localparam beat_t NB = '0;
    localparam int PHASE_ITEMS = 74;
    localparam int LONG_HOLD = 80;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       mode = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last;

    json_string_unescape_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_byte   (out_byte),
        .error_code (error_code),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder shadow state
    logic        esc_seen = 1'b0;
    logic        in_uni = 1'b0;
    logic [2:0]  hex_cnt = 3'd0;
    logic [15:0] cp = 16'h0000;
    logic        err_held = 1'b0;

    beat_t pred [3];
    int    pred_n;
    beat_t decoded_q [$];

    // expectations typed into the directed table ride along with the beat
    int    typed_n = -1;
    beat_t typed_exp [3];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic burst_req = 1'b0;

    int mismatches = 0;
    int beats_in = 0;
    int useful_beats = 0;
    int beats_out = 0;
    int closes_seen = 0;
    int errors_seen = 0;
    int qi;

    logic       dir_m [$];
    logic [7:0] dir_b [$];
    int         dir_n [$];
    beat_t      dir_e [$];

    function automatic beat_t mk(kind_t k, logic [7:0] d, err_t c, logic f);
        beat_t r;
        r.kind = k;
        r.data = d;
        r.code = c;
        r.fin = f;
        return r;
    endfunction

    function automatic int hex_val(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        if ($urandom_range(0, 1) == 1)
            return 8'h41 + 8'(v) - 8'd10;
        return 8'h61 + 8'(v) - 8'd10;
    endfunction

    task automatic push_pred(kind_t k, logic [7:0] d, err_t c);
        pred[pred_n] = mk(k, d, c, 1'b0);
        pred_n++;
    endtask

    task automatic decode_beat(input logic m, input logic [7:0] b);
        int v;
        pred_n = 0;
        if (m) begin
            if (!err_held) begin
                if (in_uni)
                    push_pred(KIND_ERROR, 8'h00, ERR_TRUNCATED);
                else if (esc_seen)
                    push_pred(KIND_ERROR, 8'h00, ERR_MISSING);
            end
            push_pred(KIND_END, 8'h00, ERR_NONE);
            esc_seen = 1'b0;
            in_uni = 1'b0;
            hex_cnt = 3'd0;
            cp = 16'h0000;
            err_held = 1'b0;
        end else if (err_held) begin
            pred_n = 0;
        end else if (in_uni) begin
            v = hex_val(b);
            if (v < 0) begin
                in_uni = 1'b0;
                hex_cnt = 3'd0;
                cp = 16'h0000;
                err_held = 1'b1;
                push_pred(KIND_ERROR, 8'h00, ERR_BAD_HEX);
            end else begin
                cp = {cp[11:0], 4'(v)};
                hex_cnt = hex_cnt + 3'd1;
                if (hex_cnt == 3'd4) begin
                    if (cp < 16'h0080) begin
                        push_pred(KIND_BYTE, cp[7:0], ERR_NONE);
                    end else if (cp < 16'h0800) begin
                        push_pred(KIND_BYTE, {3'b110, cp[10:6]}, ERR_NONE);
                        push_pred(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
                    end else begin
                        push_pred(KIND_BYTE, {4'b1110, cp[15:12]}, ERR_NONE);
                        push_pred(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NONE);
                        push_pred(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
                    end
                    in_uni = 1'b0;
                    hex_cnt = 3'd0;
                    cp = 16'h0000;
                end
            end
        end else if (esc_seen) begin
            esc_seen = 1'b0;
            case (b) inside
                CH_QUOTE, CH_BSLASH, CH_SLASH: push_pred(KIND_BYTE, b, ERR_NONE);
                CH_LC_B: push_pred(KIND_BYTE, CH_BS, ERR_NONE);
                CH_LC_F: push_pred(KIND_BYTE, CH_FF, ERR_NONE);
                CH_LC_N: push_pred(KIND_BYTE, CH_LF, ERR_NONE);
                CH_LC_R: push_pred(KIND_BYTE, CH_CR, ERR_NONE);
                CH_LC_T: push_pred(KIND_BYTE, CH_TAB, ERR_NONE);
                CH_LC_U:
                begin
                    in_uni = 1'b1;
                    hex_cnt = 3'd0;
                    cp = 16'h0000;
                end
                default:
                begin
                    err_held = 1'b1;
                    push_pred(KIND_ERROR, 8'h00, ERR_UNKNOWN_ESCAPE);
                end
            endcase
        end else if (b == CH_BSLASH) begin
            esc_seen = 1'b1;
        end else if (b == CH_QUOTE) begin
            push_pred(KIND_CLOSE, 8'h00, ERR_NONE);
        end else begin
            push_pred(KIND_BYTE, b, ERR_NONE);
        end
        if (pred_n > 0)
            pred[pred_n - 1].fin = 1'b1;
    endtask

    task automatic flag(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 25)
            $display("mismatch on %s: got %0h, want %0h (result beat %0d, %0t)",
                     what, got, want, beats_out, $time);
    endtask

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                beats_in++;
                if (mode || !err_held)
                    useful_beats++;
                decode_beat(mode, in_byte);
                if (typed_n >= 0) begin
                    for (qi = 0; qi < typed_n; qi++)
                        decoded_q.insert(decoded_q.size(), typed_exp[qi]);
                end else begin
                    for (qi = 0; qi < pred_n; qi++)
                        decoded_q.insert(decoded_q.size(), pred[qi]);
                end
            end
            if (out_valid && !out_stall) begin
                beats_out++;
                if (kind == KIND_CLOSE)
                    closes_seen++;
                if (kind == KIND_ERROR)
                    errors_seen++;
                if (decoded_q.size() == 0) begin
                    flag("result beat with nothing expected", int'(kind), -1);
                end else begin
                    if (kind !== decoded_q[0].kind)
                        flag("kind", int'(kind), int'(decoded_q[0].kind));
                    if (out_byte !== decoded_q[0].data)
                        flag("out_byte", int'(out_byte), int'(decoded_q[0].data));
                    if (error_code !== decoded_q[0].code)
                        flag("error_code", int'(error_code), int'(decoded_q[0].code));
                    if (last !== decoded_q[0].fin)
                        flag("last", int'(last), int'(decoded_q[0].fin));
                    void'(decoded_q.pop_front());
                end
            end
        end
    end

    initial
    begin : rx_side
        int c;
        forever begin
            @(posedge clk);
            if (burst_req) begin
                burst_req = 1'b0;
                out_stall <= 1'b1;
                for (c = 0; c < LONG_HOLD; c++)
                    @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    task automatic offer(input logic m, input logic [7:0] b, input int n,
                         input beat_t e0, input beat_t e1, input beat_t e2);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        in_byte <= b;
        typed_n <= n;
        typed_exp[0] <= e0;
        typed_exp[1] <= e1;
        typed_exp[2] <= e2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic text(input logic [7:0] b);
        offer(1'b0, b, -1, NB, NB, NB);
    endtask

    task automatic eot();
        offer(1'b1, 8'($urandom_range(0, 255)), -1, NB, NB, NB);
    endtask

    task automatic row(input logic m, input logic [7:0] b, input int n,
                       input beat_t e0, input beat_t e1, input beat_t e2);
        dir_m.insert(dir_m.size(), m);
        dir_b.insert(dir_b.size(), b);
        dir_n.insert(dir_n.size(), n);
        dir_e.insert(dir_e.size(), e0);
        dir_e.insert(dir_e.size(), e1);
        dir_e.insert(dir_e.size(), e2);
    endtask

    task automatic emit_segment();
        int r;
        int i;
        int cnt;
        logic [15:0] val;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            c = 8'($urandom_range(0, 255));
            while (c == CH_BSLASH || c == CH_QUOTE)
                c = 8'($urandom_range(0, 255));
            text(c);
        end else if (r < 55) begin
            text(CH_BSLASH);
            case ($urandom_range(0, 7))
                0: text(CH_QUOTE);
                1: text(CH_BSLASH);
                2: text(CH_SLASH);
                3: text(CH_LC_B);
                4: text(CH_LC_F);
                5: text(CH_LC_N);
                6: text(CH_LC_R);
                default: text(CH_LC_T);
            endcase
        end else if (r < 72) begin
            case ($urandom_range(0, 3))
                0: val = 16'($urandom_range(0, 16'h007F));
                1: val = 16'($urandom_range(16'h0080, 16'h07FF));
                2: val = 16'($urandom_range(16'h0800, 16'hFFFF));
                default:
                begin
                    case ($urandom_range(0, 5))
                        0: val = 16'h0000;
                        1: val = 16'h007F;
                        2: val = 16'h0080;
                        3: val = 16'h07FF;
                        4: val = 16'h0800;
                        default: val = 16'hFFFF;
                    endcase
                end
            endcase
            text(CH_BSLASH);
            text(CH_LC_U);
            for (i = 3; i >= 0; i--)
                text(hex_char(val[i*4 +: 4]));
        end else if (r < 80) begin
            text(CH_QUOTE);
        end else if (r < 85) begin
            eot();
        end else if (r < 90) begin
            c = 8'($urandom_range(0, 255));
            while (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_LC_B ||
                   c == CH_LC_F || c == CH_LC_N || c == CH_LC_R || c == CH_LC_T ||
                   c == CH_LC_U)
                c = 8'($urandom_range(0, 255));
            text(CH_BSLASH);
            text(c);
            if ($urandom_range(0, 1) == 1)
                eot();
        end else if (r < 97) begin
            cnt = $urandom_range(0, 3);
            text(CH_BSLASH);
            text(CH_LC_U);
            for (i = 0; i < cnt; i++)
                text(hex_char(4'($urandom_range(0, 15))));
            if (r < 94) begin
                if ($urandom_range(0, 3) == 0) begin
                    c = CH_QUOTE;
                end else begin
                    c = 8'($urandom_range(0, 255));
                    while (hex_val(c) >= 0)
                        c = 8'($urandom_range(0, 255));
                end
                text(c);
                if ($urandom_range(0, 1) == 1)
                    eot();
            end else begin
                eot();
            end
        end else begin
            text(CH_BSLASH);
            eot();
        end
    endtask

    initial
    begin : stimulus
        int i;
        int goal;
        int guard;

        row(1'b1, 8'hA5, 1, mk(KIND_END, 8'h00, ERR_NONE, 1'b1), NB, NB);
        row(1'b0, 8'h00, 1, mk(KIND_BYTE, 8'h00, ERR_NONE, 1'b1), NB, NB);
        row(1'b0, 8'hFF, 1, mk(KIND_BYTE, 8'hFF, ERR_NONE, 1'b1), NB, NB);
        row(1'b0, CH_QUOTE, 1, mk(KIND_CLOSE, 8'h00, ERR_NONE, 1'b1), NB, NB);
        row(1'b0, CH_BSLASH, 0, NB, NB, NB);
        row(1'b0, CH_LC_N, -1, NB, NB, NB);
        row(1'b0, CH_BSLASH, 0, NB, NB, NB);
        row(1'b0, CH_LC_U, 0, NB, NB, NB);
        row(1'b0, "F", -1, NB, NB, NB);
        row(1'b0, "f", -1, NB, NB, NB);
        row(1'b0, "F", -1, NB, NB, NB);
        row(1'b0, "f", 3, mk(KIND_BYTE, 8'hEF, ERR_NONE, 1'b0),
            mk(KIND_BYTE, 8'hBF, ERR_NONE, 1'b0), mk(KIND_BYTE, 8'hBF, ERR_NONE, 1'b1));
        // unknown escape, then a byte dropped under the held error
        row(1'b0, CH_BSLASH, 0, NB, NB, NB);
        row(1'b0, "q", 1, mk(KIND_ERROR, 8'h00, ERR_UNKNOWN_ESCAPE, 1'b1), NB, NB);
        row(1'b0, "x", 0, NB, NB, NB);
        row(1'b1, 8'h00, 1, mk(KIND_END, 8'h00, ERR_NONE, 1'b1), NB, NB);
        row(1'b0, CH_BSLASH, 0, NB, NB, NB);
        row(1'b1, 8'hFF, 2, mk(KIND_ERROR, 8'h00, ERR_MISSING, 1'b0),
            mk(KIND_END, 8'h00, ERR_NONE, 1'b1), NB);
        // quote inside a unicode escape is a bad digit
        row(1'b0, CH_BSLASH, 0, NB, NB, NB);
        row(1'b0, CH_LC_U, 0, NB, NB, NB);
        row(1'b0, "0", 0, NB, NB, NB);
        row(1'b0, CH_QUOTE, 1, mk(KIND_ERROR, 8'h00, ERR_BAD_HEX, 1'b1), NB, NB);
        row(1'b1, 8'h5A, 1, mk(KIND_END, 8'h00, ERR_NONE, 1'b1), NB, NB);
        row(1'b0, CH_BSLASH, 0, NB, NB, NB);
        row(1'b0, CH_LC_U, 0, NB, NB, NB);
        row(1'b0, "7", 0, NB, NB, NB);
        row(1'b1, 8'h00, 2, mk(KIND_ERROR, 8'h00, ERR_TRUNCATED, 1'b0),
            mk(KIND_END, 8'h00, ERR_NONE, 1'b1), NB);

        tx_idle_pct = 9;
        rx_idle_pct = 77;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < dir_m.size(); i++)
            offer(dir_m[i], dir_b[i], dir_n[i], dir_e[3*i], dir_e[3*i+1], dir_e[3*i+2]);

        goal = beats_in + PHASE_ITEMS;
        while (beats_in < goal)
            emit_segment();

        tx_idle_pct = 77;
        rx_idle_pct = 9;
        goal = beats_in + PHASE_ITEMS;
        while (beats_in < goal)
            emit_segment();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        burst_req = 1'b1;
        goal = beats_in + PHASE_ITEMS;
        while (beats_in < goal)
            emit_segment();
        eot();
        in_valid <= 1'b0;

        guard = 0;
        while (decoded_q.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (decoded_q.size() != 0)
            flag("result beats never delivered", 0, decoded_q.size());

        $display("run covered %0d input beats (%0d outside held errors), %0d result beats",
                 beats_in, useful_beats, beats_out);
        $display("  with %0d string closes, %0d error reports, one %0d-cycle output hold-off",
                 closes_seen, errors_seen, LONG_HOLD);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
